@@ rtl/positional_list_engine_top_assert.svh @@
// assertion macros shared by the list engine
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// checked only outside reset
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } ple_cmd_e;

  localparam int unsigned KeyW = 8;
  localparam int unsigned PosW = 5;

  typedef struct packed {
    ple_cmd_e            cmd;
    logic [PosW-1:0]     position;
    logic [KeyW-1:0]     key;
  } ple_in_t;

  typedef struct packed {
    logic                ok;
    logic [KeyW-1:0]     value;
    logic [PosW-1:0]     found_at;
    logic [PosW-1:0]     length;
    logic                empty_res;
  } ple_out_t;

  // per-cell control, decoded once per beat by the top level
  typedef struct packed {
    logic                live;
    logic                sel;
    logic                load;
    logic                take_left;
    logic                take_right;
    logic [KeyW-1:0]     key;
  } ple_cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ple_cell.sv @@
`default_nettype none

module ple_cell (
  input  logic                                clk_i,
  input  ple_pkg::ple_cell_ctl_t              ctl_i,
  input  logic [ple_pkg::KeyW-1:0]            left_i,
  input  logic [ple_pkg::KeyW-1:0]            right_i,
  output logic [ple_pkg::KeyW-1:0]            slot_o,
  output logic                                match_o,
  output logic [ple_pkg::KeyW-1:0]            rd_o
);
  import ple_pkg::*;

  logic [KeyW-1:0] slot_q;
  logic [KeyW-1:0] slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.load) begin
      slot_d = ctl_i.key;
    end else if (ctl_i.take_left) begin
      slot_d = left_i;
    end else if (ctl_i.take_right) begin
      slot_d = right_i;
    end
  end

  // key storage carries no reset
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o  = slot_q;
  assign match_o = ctl_i.live && (slot_q == ctl_i.key);
  assign rd_o    = slot_q & {KeyW{ctl_i.sel}};

endmodule

`default_nettype wire

@@ rtl/ple_pick.sv @@
`default_nettype none

module ple_pick #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0]            hit_i,
  output logic                    any_o,
  output logic [$clog2(N)-1:0]    idx_o
);
  import ple_pkg::*;

  localparam int unsigned IdxW = $clog2(N);

  logic [N-1:0] first;

  // isolate lowest set bit
  assign first = hit_i & (~hit_i + N'(1));
  assign any_o = |hit_i;

  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (first[i]) begin
        idx_o = idx_o | IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/positional_list_engine_top.sv @@
// ordered list of byte keys, 1-based positions, up to CAPACITY entries
//
// input channel: in_valid_i / in_stall_o carry one command beat
// (cmd, position, key); a beat is taken when valid is high and stall low
// output channel: out_valid_o / out_stall_i carry one result beat per
// command (ok, value, found_at, length, empty_res)
//
// every command finishes in one cycle: the keys live in a row of cells
// that shift toward or away from their neighbors together, every cell
// compares its key against the locate key at once, and a lowest-bit
// pick names the first match; the result shows one cycle after the
// command beat and a new command may be taken every cycle
//
// the result sits in an output register; while the receiver stalls and a
// result is waiting, in_stall_o is high and nothing is taken
//
// reset clears the entry count and the output valid; key cells are not
// cleared, entries at or above the count are never read
`include "positional_list_engine_top_assert.svh"

`default_nettype none

module positional_list_engine_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ple_pkg::ple_in_t   in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ple_pkg::ple_out_t  out_beat_o
);
  import ple_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  // compare width roomy enough for position, count and count + 1
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  // entry count
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  // output register
  logic     out_valid_q;
  ple_out_t out_q;
  ple_out_t res;

  logic acc;
  logic [CmpW-1:0] pos_w;
  logic [CmpW-1:0] cnt_w;
  logic [CmpW-1:0] len_w;
  logic ins_ok;
  logic del_ok;
  logic get_ok;
  logic do_ins;
  logic do_del;
  logic do_get;
  logic is_loc;

  // cell row wiring
  logic [KeyW-1:0]     slot   [CAPACITY];
  logic [KeyW-1:0]     rd     [CAPACITY];
  logic [CAPACITY-1:0] match;
  ple_cell_ctl_t       ctl    [CAPACITY];
  logic [KeyW-1:0]     rd_any;

  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic [CmpW-1:0] found_w;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  assign pos_w = CmpW'(in_beat_i.position);
  assign cnt_w = CmpW'(count_q);

  // range checks against the count before the command
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CmpW'(1))
               && (cnt_w < CmpW'(CAPACITY));
  assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign get_ok = del_ok;

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    do_get = 1'b0;
    is_loc = 1'b0;
    unique case (in_beat_i.cmd)
      CMD_INSERT: do_ins = ins_ok;
      CMD_DELETE: do_del = del_ok;
      CMD_GET:    do_get = get_ok;
      CMD_LOCATE: is_loc = 1'b1;
      default:    is_loc = 1'b0;
    endcase
  end

  // the row of cells, each handed its neighbors' keys every cycle
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CmpW-1:0] Iw = CmpW'(i);
    logic [KeyW-1:0] left_key;
    logic [KeyW-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = '0;
    end else begin : g_mid_l
      assign left_key = slot[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
    end else begin : g_mid_r
      assign right_key = slot[i+1];
    end

    always_comb begin
      ctl[i].live       = Iw < cnt_w;
      ctl[i].sel        = (Iw + CmpW'(1)) == pos_w;
      // insert: the slot at the position takes the key, those past it shift up
      ctl[i].load       = acc && do_ins && ((Iw + CmpW'(1)) == pos_w);
      ctl[i].take_left  = acc && do_ins && (Iw >= pos_w);
      // delete: the slot at the position and those past it pull down
      ctl[i].take_right = acc && do_del && ((Iw + CmpW'(1)) >= pos_w);
      ctl[i].key        = in_beat_i.key;
    end

    ple_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[i]),
      .left_i  (left_key),
      .right_i (right_key),
      .slot_o  (slot[i]),
      .match_o (match[i]),
      .rd_o    (rd[i])
    );
  end

  // get: only the selected cell drives its key, the rest give zero
  always_comb begin
    rd_any = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd[i];
    end
  end

  // locate: first live cell holding the key
  ple_pick #(
    .N (CAPACITY)
  ) u_pick (
    .hit_i (match),
    .any_o (hit),
    .idx_o (hit_idx)
  );

  assign found_w = hit ? (CmpW'(hit_idx) + CmpW'(1)) : '0;

  always_comb begin
    count_d = count_q;
    if (acc && do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (acc && do_del) begin
      count_d = count_q - CntW'(1);
    end
  end

  // count widened so the 5-bit length field can always be sliced from it
  assign len_w = CmpW'(count_d);

  always_comb begin
    res.ok        = do_ins || do_del || do_get || is_loc;
    res.value     = do_get ? rd_any : '0;
    res.found_at  = is_loc ? found_w[PosW-1:0] : '0;
    res.length    = len_w[PosW-1:0];
    res.empty_res = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `PLE_ASSERT(a_count_bound, CmpW'(count_q) <= CmpW'(CAPACITY), "count past capacity")
  `PLE_ASSERT(a_ins_grows, (acc && do_ins) |=> (count_q == $past(count_q) + CntW'(1)), "insert count")
  `PLE_ASSERT(a_idle_holds, !acc |=> $stable(count_q), "count moved without a beat")
  `PLE_ASSERT(a_result_follows, acc |=> out_valid_q, "accepted beat gave no result")

endmodule

`default_nettype wire
